FILE: rtl/mveb_pkg.sv
// shared types and constants of the variable-edge binner
package mveb_pkg;

  // number of value ports on the event word
  localparam int VALUE_DIMS = 4;

  // configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes on the configuration port
  localparam logic [2:0] REG_DIMS   = 3'd0;
  localparam logic [2:0] REG_STEPS0 = 3'd1;
  localparam logic [2:0] REG_STEPS1 = 3'd2;
  localparam logic [2:0] REG_STEPS2 = 3'd3;
  localparam logic [2:0] REG_STEPS3 = 3'd4;

  // command codes of an input word
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef struct packed {
    logic [2:0]                  dims;
    logic [VALUE_DIMS-1:0][3:0]  steps;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CMP,
    ST_FINISH
  } seq_state_t;

endpackage

FILE: rtl/mveb_ram.sv
// generic single-write, single-read ram with registered read data
module mveb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mveb_cfg.sv
// apb register file: active dimension count and per-dimension step counts
module mveb_cfg import mveb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dims  <= 3'd1;
      cfg.steps <= {VALUE_DIMS{4'd1}};
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIMS:   cfg.dims     <= pwdata[2:0];
        REG_STEPS0: cfg.steps[0] <= pwdata[3:0];
        REG_STEPS1: cfg.steps[1] <= pwdata[3:0];
        REG_STEPS2: cfg.steps[2] <= pwdata[3:0];
        REG_STEPS3: cfg.steps[3] <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIMS:   prdata = {29'd0, cfg.dims};
      REG_STEPS0: prdata = {28'd0, cfg.steps[0]};
      REG_STEPS1: prdata = {28'd0, cfg.steps[1]};
      REG_STEPS2: prdata = {28'd0, cfg.steps[2]};
      REG_STEPS3: prdata = {28'd0, cfg.steps[3]};
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/mveb_seq.sv
// sequencer: edge search with one shared comparator and horner index build
module mveb_seq import mveb_pkg::*; #(
  parameter int MAX_DIMS  = 4,
  parameter int MAX_EDGES = 16,
  parameter int AW        = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic               passed,
  input  logic [1:0]         edge_dim,
  input  logic [3:0]         edge_slot,
  input  logic signed [31:0] edge_value,
  input  logic signed [31:0] value_zero,
  input  logic signed [31:0] value_one,
  input  logic signed [31:0] value_two,
  input  logic signed [31:0] value_three,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [31:0]        ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  logic [31:0]        ram_rdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        bin_index,
  output logic               rejected,
  output logic               above_range
);

  localparam int DimLim   = (MAX_DIMS < VALUE_DIMS) ? MAX_DIMS : VALUE_DIMS;
  localparam int StepsMax = MAX_EDGES - 1;

  seq_state_t state, state_next;

  logic signed [31:0] vals [VALUE_DIMS];
  logic [1:0]         d;
  logic [3:0]         e;
  logic [15:0]        acc;
  logic               above;
  logic               rej;

  logic [3:0]  steps_sat [VALUE_DIMS];
  logic [2:0]  dims_act;
  logic [1:0]  start_d;
  logic [3:0]  steps_d;
  logic        in_accept;
  logic        gt;
  logic        last_edge;
  logic [3:0]  bin;
  logic [15:0] prod;
  logic        out_load;

  // clamp the configured counts to what the table holds
  always_comb begin
    for (int i = 0; i < VALUE_DIMS; i++) begin
      steps_sat[i] = cfg.steps[i];
      if (steps_sat[i] == 4'd0) begin
        steps_sat[i] = 4'd1;
      end
      if (int'(steps_sat[i]) > StepsMax) begin
        steps_sat[i] = 4'(StepsMax);
      end
    end
    dims_act = cfg.dims;
    if (dims_act == 3'd0) begin
      dims_act = 3'd1;
    end
    if (int'(dims_act) > DimLim) begin
      dims_act = 3'(DimLim);
    end
  end

  assign start_d   = 2'(dims_act - 3'd1);
  assign steps_d   = steps_sat[d];
  assign in_accept = in_valid && !in_stall;

  // edge load path, writes only from idle
  assign ram_we    = in_accept && (command == CMD_LOAD) &&
                     (int'(edge_dim) < MAX_DIMS) && (int'(edge_slot) < MAX_EDGES);
  assign ram_waddr = AW'(int'(edge_dim) * MAX_EDGES + int'(edge_slot));
  assign ram_wdata = edge_value;
  assign ram_raddr = AW'(int'(d) * MAX_EDGES + int'(e));

  // shared comparator against the edge just read
  assign gt        = vals[d] > $signed(ram_rdata);
  assign last_edge = (e == steps_d);
  assign bin       = gt ? (steps_d - 4'd1) : (e - 4'd1);
  // largest bin index is 15^4 - 1, so the product never leaves 16 bits
  assign prod      = acc * {12'd0, steps_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (command == CMD_CLASSIFY)) begin
          state_next = passed ? ST_ISSUE : ST_FINISH;
        end
      end
      ST_ISSUE: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (gt && !last_edge) begin
          state_next = ST_ISSUE;
        end else if (d == 2'd0) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept && (command == CMD_CLASSIFY)) begin
      vals[0] <= value_zero;
      vals[1] <= value_one;
      vals[2] <= value_two;
      vals[3] <= value_three;
      d       <= start_d;
      e       <= 4'd1;
      acc     <= '0;
      above   <= 1'b0;
      rej     <= !passed;
    end else if (state == ST_CMP) begin
      if (gt && !last_edge) begin
        e <= e + 4'd1;
      end else begin
        // horner step from the top dimension down
        acc   <= prod + {12'd0, bin};
        above <= above || (gt && last_edge);
        if (d != 2'd0) begin
          d <= d - 2'd1;
          e <= 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bin_index   <= acc;
      rejected    <= rej;
      above_range <= above;
    end
  end

  a_rej_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> (bin_index == 16'd0) && !above_range)
    else $error("rejected word carries index or overflow flag");

  a_edge_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> (e != 4'd0) && (e <= steps_d))
    else $error("edge slot outside the active step range");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_IDLE)
    else $error("edge table written during a search");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    out_load |=> bin_index <= 16'd50624)
    else $error("bin index beyond the largest grid");

endmodule

FILE: rtl/multidim_variable_edge_binner_core.sv
// variable-edge binner top level: up to four q16.16 values map to one flat bin index
// load word: written at its accept edge, the next word can follow on the next cycle
// classify word: each edge compared takes an issue state (ram read), then a compare state (shared compare),
// then the word passes a finish state, which holds while the output is held, and returns to idle
// rejected word: goes from idle straight to the finish state; a held result stalls input
// reset clears sequencer, output valid and config (all 1); the edge table must be loaded first
module multidim_variable_edge_binner_core import mveb_pkg::*; #(
  parameter int MAX_DIMS  = 4,
  parameter int MAX_EDGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic               passed,
  input  logic [1:0]         edge_dim,
  input  logic [3:0]         edge_slot,
  input  logic signed [31:0] edge_value,
  input  logic signed [31:0] value_zero,
  input  logic signed [31:0] value_one,
  input  logic signed [31:0] value_two,
  input  logic signed [31:0] value_three,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        bin_index,
  output logic               rejected,
  output logic               above_range
);

  localparam int TableDepth = MAX_DIMS * MAX_EDGES;
  localparam int TableAw    = $clog2(TableDepth);

  cfg_t               cfg;
  logic               ram_we;
  logic [TableAw-1:0] ram_waddr;
  logic [31:0]        ram_wdata;
  logic [TableAw-1:0] ram_raddr;
  logic [31:0]        ram_rdata;

  mveb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mveb_ram #(
    .WIDTH (32),
    .DEPTH (TableDepth)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mveb_seq #(
    .MAX_DIMS  (MAX_DIMS),
    .MAX_EDGES (MAX_EDGES),
    .AW        (TableAw)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .passed      (passed),
    .edge_dim    (edge_dim),
    .edge_slot   (edge_slot),
    .edge_value  (edge_value),
    .value_zero  (value_zero),
    .value_one   (value_one),
    .value_two   (value_two),
    .value_three (value_three),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bin_index   (bin_index),
    .rejected    (rejected),
    .above_range (above_range)
  );

endmodule

FILE: tb/multidim_variable_edge_binner_core_test.sv
// self-checking testbench for the variable-edge binner core: edge loads, classification, config
module multidim_variable_edge_binner_core_test import mveb_pkg::*; ();

  localparam int MAX_DIMS    = 4;
  localparam int MAX_EDGES   = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_ITEMS  = 40;

  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    logic             command;
    logic             passed;
    logic [1:0]       edge_dim;
    logic [3:0]       edge_slot;
    logic [31:0]      edge_value;
    logic [3:0][31:0] vals;
  } event_word_t;

  typedef struct packed {
    logic [15:0] bin_index;
    logic        rejected;
    logic        above_range;
  } bin_result_t;

  typedef struct packed {
    logic        command;
    logic        passed;
    logic [1:0]  edge_dim;
    logic [3:0]  edge_slot;
    logic [31:0] edge_value;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [31:0] v3;
    logic        fixed;
    logic [15:0] bin_index;
    logic        rejected;
    logic        above_range;
  } dir_row_t;

  typedef struct packed {
    logic [2:0]  dims;
    logic [3:0]  s0;
    logic [3:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  s3;
    logic [10:0] items;
  } phase_t;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_RANDOM,
    FLOW_PULSE
  } flow_t;

  localparam int N_DIRECTED = 21;
  // reset config: one dimension with a single bin, so only slot 1 of dim 0 matters
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{CMD_LOAD, 1'b1, 2'd0, 4'd1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b0, 2'd3, 4'd15, Q_MAX, Q_MAX, Q_MIN, 32'hFFFF_FFFF, 32'h0,
      1'b1, 16'd0, 1'b1, 1'b0},
    // equal to the edge does not exceed it
    '{CMD_CLASSIFY, 1'b1, 2'd0, 4'd0, Q_MIN, 32'h0, Q_MAX, Q_MAX, Q_MAX,
      1'b1, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b1, 2'd1, 4'd2, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0,
      1'b1, 16'd0, 1'b0, 1'b1},
    '{CMD_CLASSIFY, 1'b1, 2'd2, 4'd4, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN,
      1'b1, 16'd0, 1'b0, 1'b1},
    '{CMD_CLASSIFY, 1'b1, 2'd3, 4'd8, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
      1'b1, 16'd0, 1'b0, 1'b0},
    '{CMD_LOAD, 1'b0, 2'd0, 4'd1, Q_MIN, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b1, 2'd0, 4'd0, 32'h0, Q_MIN, 32'h0, 32'h0, 32'h0,
      1'b1, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b1, 2'd0, 4'd0, 32'h0, 32'h8000_0001, 32'h0, 32'h0, 32'h0,
      1'b1, 16'd0, 1'b0, 1'b1},
    '{CMD_LOAD, 1'b1, 2'd0, 4'd1, Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b1, 2'd0, 4'd0, 32'h0, Q_MAX, 32'h0, 32'h0, 32'h0,
      1'b1, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b1, 2'd0, 4'd0, 32'h0, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
      1'b1, 16'd0, 1'b0, 1'b0},
    // loads into other dims and the unused lower-edge slot
    '{CMD_LOAD, 1'b0, 2'd3, 4'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_LOAD, 1'b0, 2'd3, 4'd15, Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_LOAD, 1'b0, 2'd2, 4'd8, Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_LOAD, 1'b0, 2'd1, 4'd1, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_LOAD, 1'b0, 2'd0, 4'd1, 32'h0001_8000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b1, 2'd1, 4'd3, 32'h0, 32'h0001_8000, Q_MIN, Q_MAX, 32'h0,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b1, 2'd2, 4'd5, 32'h0, 32'h0001_8001, Q_MAX, Q_MIN, 32'h0,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b1, 2'd3, 4'd6, 32'h0, 32'h0001_7FFF, Q_MAX, Q_MAX, Q_MIN,
      1'b0, 16'd0, 1'b0, 1'b0},
    '{CMD_CLASSIFY, 1'b0, 2'd0, 4'd9, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
      1'b1, 16'd0, 1'b1, 1'b0}
  };

  localparam int N_PHASES   = 10;
  localparam int JUNK_PHASE = 1;
  localparam int HOLD_PHASE = 5;
  localparam phase_t PHASES [N_PHASES] = '{
    '{3'd2, 4'd3,  4'd4,  4'd1,  4'd1,  11'd140},
    '{3'd0, 4'd0,  4'd0,  4'd0,  4'd0,  11'd80},
    '{3'd4, 4'd15, 4'd15, 4'd15, 4'd15, 11'd30},
    '{3'd7, 4'd2,  4'd3,  4'd2,  4'd5,  11'd140},
    '{3'd1, 4'd15, 4'd1,  4'd1,  4'd1,  11'd120},
    '{3'd3, 4'd5,  4'd7,  4'd0,  4'd9,  11'd140},
    '{3'd4, 4'd1,  4'd1,  4'd1,  4'd1,  11'd100},
    '{3'd2, 4'd15, 4'd15, 4'd3,  4'd3,  11'd110},
    '{3'd5, 4'd4,  4'd2,  4'd6,  4'd3,  11'd120},
    '{3'd1, 4'd2,  4'd9,  4'd9,  4'd9,  11'd90}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = CMD_LOAD;
  logic               passed = 1'b0;
  logic [1:0]         edge_dim = '0;
  logic [3:0]         edge_slot = '0;
  logic signed [31:0] edge_value = '0;
  logic signed [31:0] value_zero = '0;
  logic signed [31:0] value_one = '0;
  logic signed [31:0] value_two = '0;
  logic signed [31:0] value_three = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        bin_index;
  logic               rejected;
  logic               above_range;

  // shadow of the block state
  cfg_t        shadow_cfg;
  bit [31:0]   edge_mem [MAX_DIMS*MAX_EDGES];
  bin_result_t bins_due [$];

  int   fail_count = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  logic hold_pending = 1'b0;

  multidim_variable_edge_binner_core #(
    .MAX_DIMS  (MAX_DIMS),
    .MAX_EDGES (MAX_EDGES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .passed      (passed),
    .edge_dim    (edge_dim),
    .edge_slot   (edge_slot),
    .edge_value  (edge_value),
    .value_zero  (value_zero),
    .value_one   (value_one),
    .value_two   (value_two),
    .value_three (value_three),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bin_index   (bin_index),
    .rejected    (rejected),
    .above_range (above_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  function automatic void log_fail(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void expect_word(bin_result_t want);
    bins_due.insert(bins_due.size(), want);
  endfunction

  function automatic int active_dims();
    int nd;
    nd = shadow_cfg.dims;
    if (nd == 0) nd = 1;
    if (nd > MAX_DIMS) nd = MAX_DIMS;
    return nd;
  endfunction

  function automatic int eff_steps(int d);
    int st;
    st = shadow_cfg.steps[d];
    if (st == 0) st = 1;
    if (st > MAX_EDGES - 1) st = MAX_EDGES - 1;
    return st;
  endfunction

  // count the leading upper edges each value exceeds, combine in mixed radix
  function automatic bin_result_t bin_event(event_word_t w);
    bin_result_t r;
    int          nd, st, bin, stride, idx, d, e;
    logic        above;
    r = '0;
    if (!w.passed) begin
      r.rejected = 1'b1;
      return r;
    end
    nd = active_dims();
    stride = 1;
    idx = 0;
    above = 1'b0;
    for (d = 0; d < nd; d++) begin
      st = eff_steps(d);
      bin = 0;
      for (e = 1; e <= st; e++) begin
        if ($signed(w.vals[d]) <= $signed(edge_mem[d*MAX_EDGES + e])) break;
        bin++;
      end
      if (bin >= st) begin
        bin = st - 1;
        above = 1'b1;
      end
      idx += bin * stride;
      stride *= st;
    end
    r.bin_index = idx[15:0];
    r.above_range = above;
    return r;
  endfunction

  // value close to one of the active edges, an extreme, or a random value
  function automatic logic [31:0] pick_value(int d);
    logic [31:0] e;
    e = edge_mem[d*MAX_EDGES + $urandom_range(1, eff_steps(d))];
    case ($urandom_range(0, 7))
      0: return e;
      1: return e + 32'd1;
      2: return e - 32'd1;
      3: return $urandom;
      4: return Q_MIN;
      5: return Q_MAX;
      default: return e + 32'($urandom_range(0, 64)) - 32'd32;
    endcase
  endfunction

  function automatic event_word_t random_item();
    event_word_t w;
    int          d;
    w.edge_dim = 2'($urandom_range(0, 3));
    w.edge_slot = 4'($urandom_range(0, 15));
    w.edge_value = $urandom;
    w.passed = ($urandom_range(0, 9) != 0);
    for (d = 0; d < 4; d++) w.vals[d] = $urandom;
    // occasional stray edge load that may break the ascending order
    if ($urandom_range(0, 15) == 0) begin
      w.command = CMD_LOAD;
    end else begin
      w.command = CMD_CLASSIFY;
      for (d = 0; d < active_dims(); d++) w.vals[d] = pick_value(d);
    end
    return w;
  endfunction

  task automatic send_word(event_word_t w, logic fixed, bin_result_t want);
    in_valid <= 1'b1;
    command <= w.command;
    passed <= w.passed;
    edge_dim <= w.edge_dim;
    edge_slot <= w.edge_slot;
    edge_value <= w.edge_value;
    value_zero <= w.vals[0];
    value_one <= w.vals[1];
    value_two <= w.vals[2];
    value_three <= w.vals[3];
    do @(posedge clk); while (in_stall);
    if (w.command == CMD_LOAD) begin
      edge_mem[{w.edge_dim, w.edge_slot}] = w.edge_value;
    end else if (fixed) begin
      expect_word(want);
    end else begin
      expect_word(bin_event(w));
    end
  endtask

  // sender bursts with random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DIMS:   shadow_cfg.dims = data[2:0];
      REG_STEPS0: shadow_cfg.steps[0] = data[3:0];
      REG_STEPS1: shadow_cfg.steps[1] = data[3:0];
      REG_STEPS2: shadow_cfg.steps[2] = data[3:0];
      REG_STEPS3: shadow_cfg.steps[3] = data[3:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_regs();
    logic [2:0]  idx;
    logic [31:0] got, want;
    for (idx = REG_DIMS; idx <= REG_STEPS3; idx++) begin
      want = (idx == REG_DIMS) ? {29'd0, shadow_cfg.dims}
                               : {28'd0, shadow_cfg.steps[idx - 1]};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      if (got !== want) begin
        log_fail($sformatf("register %0d read: expected %h, got %h", idx, want, got));
      end
    end
  endtask

  // ascending edge set per active dim, lower edge included
  task automatic load_edge_sets();
    event_word_t w;
    int          nd, st, d, e;
    longint      step_max, top, base;
    nd = active_dims();
    for (d = 0; d < nd; d++) begin
      st = eff_steps(d);
      step_max = longint'(1) << $urandom_range(2, 28);
      top = 64'sd2147483647 - st * step_max;
      base = -64'sd2147483648 + longint'($urandom) % (top + 64'sd2147483648 + 1);
      for (e = 0; e <= st; e++) begin
        w = random_item();
        w.command = CMD_LOAD;
        w.edge_dim = 2'(d);
        w.edge_slot = 4'(e);
        w.edge_value = base[31:0];
        send_word(w, 1'b0, '0);
        pace();
        base += longint'($urandom) % (step_max + 1);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    bin_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (bins_due.size() == 0) begin
        log_fail($sformatf("unexpected word: bin %0d rejected %0b above %0b",
                           bin_index, rejected, above_range));
      end else begin
        want = bins_due.pop_front();
        if (bin_index !== want.bin_index || rejected !== want.rejected ||
            above_range !== want.above_range) begin
          log_fail($sformatf(
            "expected bin %0d rejected %0b above %0b, got bin %0d rejected %0b above %0b",
            want.bin_index, want.rejected, want.above_range,
            bin_index, rejected, above_range));
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin : receiver
    flow_t mode;
    int    run, k;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      mode = flow_t'($urandom_range(0, 2));
      run = $urandom_range(4, 48);
      for (k = 0; k < run; k++) begin
        case (mode)
          FLOW_FREE:   out_stall <= 1'b0;
          FLOW_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
          default:     out_stall <= ((k % 5) < 2);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d words still pending", bins_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    event_word_t w;
    dir_row_t    row;
    phase_t      ph;
    int          i, p, k, j;
    shadow_cfg.dims = 3'd1;
    for (i = 0; i < VALUE_DIMS; i++) shadow_cfg.steps[i] = 4'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_regs();

    for (i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      w.command = row.command;
      w.passed = row.passed;
      w.edge_dim = row.edge_dim;
      w.edge_slot = row.edge_slot;
      w.edge_value = row.edge_value;
      w.vals = {row.v3, row.v2, row.v1, row.v0};
      send_word(w, row.fixed, {row.bin_index, row.rejected, row.above_range});
      pace();
    end

    for (p = 0; p < N_PHASES; p++) begin
      ph = PHASES[p];
      drain();
      reg_write(REG_DIMS, {29'($urandom), ph.dims});
      reg_write(REG_STEPS0, {28'($urandom), ph.s0});
      reg_write(REG_STEPS1, {28'($urandom), ph.s1});
      reg_write(REG_STEPS2, {28'($urandom), ph.s2});
      reg_write(REG_STEPS3, {28'($urandom), ph.s3});
      if (p == JUNK_PHASE) begin
        // addresses past the register list must be ignored
        for (j = int'(REG_STEPS3) + 1; j < (1 << (CFG_AW - 2)); j++) begin
          reg_write(3'(j), $urandom);
        end
      end
      check_regs();
      load_edge_sets();
      if (p == HOLD_PHASE) begin
        hold_pending = 1'b1;
        for (k = 0; k < HOLD_ITEMS; k++) send_word(random_item(), 1'b0, '0);
      end
      for (k = 0; k < ph.items; k++) begin
        send_word(random_item(), 1'b0, '0);
        pace();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mveb_pkg.sv
rtl/mveb_ram.sv
rtl/mveb_cfg.sv
rtl/mveb_seq.sv
rtl/multidim_variable_edge_binner_core.sv
tb/multidim_variable_edge_binner_core_test.sv
